### sv/wvpd_pkg.sv
// Shared types, constants and codes for the weighted vote power detector.
`timescale 1ns / 1ps

package wvpd_pkg;

   // Sizing of the sensor array.
   localparam int NUM_SENSORS = 8;
   localparam int WEIGHT_BITS = 8;
   localparam int SLOT_BITS   = 3;
   localparam int NUM_SLOTS   = 1 << SLOT_BITS;
   localparam int VOTE_BITS   = 12;
   localparam int TOTAL_BITS  = 11;
   localparam int CMP_BITS    = 16;

   // Index of the last slot that the accumulation walks.
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SENSORS - 1);

   // Configuration register indexes.
   localparam logic [1:0] CSR_HYSTERESIS = 2'd0;
   localparam logic [1:0] CSR_ENABLE     = 2'd1;
   localparam logic [1:0] CSR_WEIGHTS    = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]  HYSTERESIS_RESET = 8'd3;
   localparam logic [7:0]  ENABLE_RESET     = 8'hFF;
   localparam logic [63:0] WEIGHTS_RESET    = 64'h0101_0101_0101_0101;

   // Vote and decided state codes.
   typedef enum logic [1:0] {
      VOTE_UNKNOWN = 2'd0,
      VOTE_ON      = 2'd1,
      VOTE_OFF     = 2'd2
   } vote_type;

   // Input beat.
   typedef struct packed {
      logic [SLOT_BITS-1:0] sensor_index;
      logic                 sensor_value;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]                   power_state;
      logic                         state_changed;
      logic signed [VOTE_BITS-1:0]  vote_sum;
      logic [TOTAL_BITS-1:0]        weight_total;
   } rsp_type;

   // Control from the sequencer to the shared accumulate unit.
   typedef struct packed {
      logic clear;
      logic add;
      logic negate;
   } acc_ctrl_type;

endpackage

### sv/wvpd_accum.sv
// Shared add/subtract unit that accumulates the signed vote and the weight total.
`timescale 1ns / 1ps

module wvpd_accum (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wvpd_pkg::acc_ctrl_type                 ctrl,
   input  logic [wvpd_pkg::WEIGHT_BITS-1:0]       weight,
   output logic signed [wvpd_pkg::VOTE_BITS-1:0]  vote_sum,
   output logic [wvpd_pkg::TOTAL_BITS-1:0]        weight_total
);

   logic signed [wvpd_pkg::VOTE_BITS-1:0] vote_ff;
   logic signed [wvpd_pkg::VOTE_BITS-1:0] vote_in;
   logic [wvpd_pkg::TOTAL_BITS-1:0]       total_ff;
   logic [wvpd_pkg::TOTAL_BITS-1:0]       total_in;
   logic signed [wvpd_pkg::VOTE_BITS-1:0] weight_s;

   assign weight_s = $signed(wvpd_pkg::VOTE_BITS'(weight));

   // One slot per cycle: the vote moves by plus or minus the weight.
   always_comb begin
      vote_in  = vote_ff;
      total_in = total_ff;
      priority if (ctrl.clear) begin
         vote_in  = '0;
         total_in = '0;
      end else if (ctrl.add) begin
         vote_in  = ctrl.negate ? (vote_ff - weight_s) : (vote_ff + weight_s);
         total_in = total_ff + wvpd_pkg::TOTAL_BITS'(weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_ff  <= '0;
         total_ff <= '0;
      end else begin
         vote_ff  <= vote_in;
         total_ff <= total_in;
      end
   end

   assign vote_sum     = vote_ff;
   assign weight_total = total_ff;

   // The magnitude of the vote can never exceed the weights that took part.
   a_vote_bounded: assert property (@(posedge clock) disable iff (reset)
      ($signed({1'b0, total_ff}) >= vote_ff) && ($signed({1'b0, total_ff}) >= -vote_ff))
      else $error("vote magnitude exceeds weight total");

   // A clear leaves both sums at zero.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (vote_ff == '0) && (total_ff == '0))
      else $error("sums not zero after clear");

   // Without a clear or an add both sums hold.
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.clear || ctrl.add) |=> $stable(vote_ff) && $stable(total_ff))
      else $error("sums moved without a request");

endmodule

### sv/weighted_vote_power_detector_top.sv
// Top level of the weighted vote power detector with debounce.
// A reading is accepted only in idle; the single shared accumulate unit then walks
// one sensor slot per cycle, and a decide step posts the result. The decide step
// waits while the previous result is not taken, and no new reading enters before it.
// A new reading may be accepted while the previous result still waits to be taken.
// Synchronous active-high reset restores the default registers and clears all vote history.
`timescale 1ns / 1ps

module weighted_vote_power_detector_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wvpd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wvpd_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   logic [wvpd_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic [wvpd_pkg::NUM_SLOTS-1:0]       reading_ff, reading_in;
   logic [wvpd_pkg::NUM_SLOTS-1:0]       seen_ff, seen_in;
   wvpd_pkg::vote_type                   prev_vote_ff, prev_vote_in;
   wvpd_pkg::vote_type                   decided_ff, decided_in;
   logic [7:0]                           repeat_ff, repeat_in;
   logic [7:0]                           hyst_ff;
   logic [7:0]                           enable_ff;
   logic [63:0]                          weights_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   wvpd_pkg::rsp_type                    rsp_ff, rsp_in;

   wvpd_pkg::acc_ctrl_type               acc_ctrl;
   logic [wvpd_pkg::WEIGHT_BITS-1:0]     slot_weight;
   logic signed [wvpd_pkg::VOTE_BITS-1:0] vote_sum;
   logic [wvpd_pkg::TOTAL_BITS-1:0]      weight_total;

   logic signed [wvpd_pkg::CMP_BITS-1:0] vote_ext;
   logic signed [wvpd_pkg::CMP_BITS-1:0] total_ext;
   logic signed [wvpd_pkg::CMP_BITS-1:0] ten_vote;
   logic signed [wvpd_pkg::CMP_BITS-1:0] three_total;
   wvpd_pkg::vote_type                   vote_now;
   logic                                 req_fire;
   logic                                 rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff    <= wvpd_pkg::HYSTERESIS_RESET;
         enable_ff  <= wvpd_pkg::ENABLE_RESET;
         weights_ff <= wvpd_pkg::WEIGHTS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wvpd_pkg::CSR_HYSTERESIS: hyst_ff    <= csr_data[7:0];
            wvpd_pkg::CSR_ENABLE:     enable_ff  <= csr_data[7:0];
            wvpd_pkg::CSR_WEIGHTS:    weights_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Weight of the slot under the walk: the byte of the weights register at that slot.
   assign slot_weight = weights_ff[{slot_ff, 3'b000} +: wvpd_pkg::WEIGHT_BITS];

   wvpd_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (acc_ctrl),
      .weight       (slot_weight),
      .vote_sum     (vote_sum),
      .weight_total (weight_total)
   );

   // Exact form of the confidence test: 10 * V against +/- 3 * W.
   assign vote_ext    = wvpd_pkg::CMP_BITS'(vote_sum);
   assign total_ext   = $signed(wvpd_pkg::CMP_BITS'(weight_total));
   assign ten_vote    = (vote_ext <<< 3) + (vote_ext <<< 1);
   assign three_total = (total_ext <<< 1) + total_ext;

   always_comb begin
      vote_now = wvpd_pkg::VOTE_UNKNOWN;
      if (weight_total != '0) begin
         priority if (ten_vote > three_total) begin
            vote_now = wvpd_pkg::VOTE_ON;
         end else if (ten_vote < -three_total) begin
            vote_now = wvpd_pkg::VOTE_OFF;
         end
      end
   end

   // Sequencer: store the reading, walk the slots, then decide and post the result.
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      reading_in   = reading_ff;
      seen_in      = seen_ff;
      prev_vote_in = prev_vote_ff;
      decided_in   = decided_ff;
      repeat_in    = repeat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      acc_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (32'(req_payload.sensor_index) < wvpd_pkg::NUM_SENSORS) begin
                  reading_in[req_payload.sensor_index] = req_payload.sensor_value;
                  seen_in[req_payload.sensor_index]    = 1'b1;
               end
               acc_ctrl.clear = 1'b1;
               slot_in        = '0;
               state_in       = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            acc_ctrl.add    = enable_ff[slot_ff] && seen_ff[slot_ff];
            acc_ctrl.negate = !reading_ff[slot_ff];
            if (slot_ff == wvpd_pkg::LAST_SLOT) begin
               state_in = ST_FINISH;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               // Debounce: count equal consecutive votes, saturating.
               if (vote_now == prev_vote_ff) begin
                  repeat_in = (repeat_ff != 8'hFF) ? repeat_ff + 8'd1 : repeat_ff;
               end else begin
                  prev_vote_in = vote_now;
                  repeat_in    = 8'd1;
               end
               rsp_in.state_changed = 1'b0;
               if ((repeat_in >= hyst_ff) && (vote_now != decided_ff)) begin
                  decided_in           = vote_now;
                  rsp_in.state_changed = 1'b1;
               end
               rsp_in.power_state  = decided_in;
               rsp_in.vote_sum     = vote_sum;
               rsp_in.weight_total = weight_total;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, history and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         reading_ff   <= '0;
         seen_ff      <= '0;
         prev_vote_ff <= wvpd_pkg::VOTE_UNKNOWN;
         decided_ff   <= wvpd_pkg::VOTE_UNKNOWN;
         repeat_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         reading_ff   <= reading_in;
         seen_ff      <= seen_in;
         prev_vote_ff <= prev_vote_in;
         decided_ff   <= decided_in;
         repeat_ff    <= repeat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The walk over the slots ends only by going to the decide step.
   a_accum_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |=> (state_ff == ST_ACCUM) || (state_ff == ST_FINISH))
      else $error("slot walk left to an unexpected state");

   // The decided state moves only in the decide step.
   a_decided_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FINISH) |=> $stable(decided_ff))
      else $error("decided state changed outside the decide step");

   // A pending change beat reports the state that is currently decided.
   a_change_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.state_changed) |-> (rsp_ff.power_state == decided_ff))
      else $error("change beat disagrees with decided state");

endmodule

### tb/tb.sv
// Self-checking testbench for the weighted vote power detector top level.
`timescale 1ns / 1ps

module tb;

   // Index that maps to no register; a write there must change nothing.
   localparam logic [1:0] CSR_NONE = 2'd3;
   localparam int LATENCY     = wvpd_pkg::NUM_SENSORS + 2;
   localparam int CYCLE_LIMIT = 300_000;
   localparam int HOLD_CYCLES = 400;

   // One row of the directed table: either a register write or a reading beat.
   typedef struct packed {
      logic              is_csr;
      logic [1:0]        csr_index;
      logic [63:0]       csr_data;
      wvpd_pkg::req_type req;
      logic              typed;
      wvpd_pkg::rsp_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   wvpd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   wvpd_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [63:0]       csr_data = '0;

   // Predictor copy of the registers and the vote history.
   logic [7:0]                     cfg_hysteresis;
   logic [7:0]                     cfg_enable;
   logic [63:0]                    cfg_weights;
   logic [wvpd_pkg::NUM_SLOTS-1:0] sensor_readings;
   logic [wvpd_pkg::NUM_SLOTS-1:0] seen_slots;
   wvpd_pkg::vote_type             last_vote;
   logic [7:0]                     run_length;
   wvpd_pkg::vote_type             held_state;

   wvpd_pkg::rsp_type expected_results[$];
   stim_row_type      directed_rows[$];

   int  error_count = 0;
   int  readings_sent = 0;
   int  csr_writes = 0;
   int  results_checked = 0;
   int  changes_seen = 0;
   int  cycle_count = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   bit  calm = 1'b0;

   weighted_vote_power_detector_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("weighted_vote_power_detector_top regression: fail");
         $finish;
      end
   end

   // Restore the predictor to its post-reset contents.
   task automatic reset_tally();
      cfg_hysteresis  = wvpd_pkg::HYSTERESIS_RESET;
      cfg_enable      = wvpd_pkg::ENABLE_RESET;
      cfg_weights     = wvpd_pkg::WEIGHTS_RESET;
      sensor_readings = '0;
      seen_slots      = '0;
      last_vote       = wvpd_pkg::VOTE_UNKNOWN;
      run_length      = '0;
      held_state      = wvpd_pkg::VOTE_UNKNOWN;
   endtask

   // Store one reading, recount the weighted vote and apply the debounce.
   function automatic wvpd_pkg::rsp_type tally_reading(input wvpd_pkg::req_type item);
      int                 votes;
      int                 total;
      int                 w;
      wvpd_pkg::vote_type vote;
      logic               changed;
      wvpd_pkg::rsp_type  r;
      votes   = 0;
      total   = 0;
      changed = 1'b0;
      if (int'(item.sensor_index) < wvpd_pkg::NUM_SENSORS) begin
         sensor_readings[item.sensor_index] = item.sensor_value;
         seen_slots[item.sensor_index]      = 1'b1;
      end
      for (int i = 0; i < wvpd_pkg::NUM_SENSORS; i++) begin
         if (cfg_enable[i] && seen_slots[i]) begin
            w = int'(cfg_weights[8*i +: wvpd_pkg::WEIGHT_BITS]);
            votes += sensor_readings[i] ? w : -w;
            total += w;
         end
      end
      // Exact form of the confidence test against plus and minus three tenths of the total.
      vote = wvpd_pkg::VOTE_UNKNOWN;
      if (total != 0) begin
         if (10 * votes > 3 * total) vote = wvpd_pkg::VOTE_ON;
         else if (10 * votes < -3 * total) vote = wvpd_pkg::VOTE_OFF;
      end
      if (vote == last_vote) begin
         if (run_length != 8'd255) run_length++;
      end else begin
         last_vote  = vote;
         run_length = 8'd1;
      end
      if (run_length >= cfg_hysteresis && vote != held_state) begin
         held_state = vote;
         changed    = 1'b1;
      end
      r.power_state   = held_state;
      r.state_changed = changed;
      r.vote_sum      = wvpd_pkg::VOTE_BITS'(votes);
      r.weight_total  = wvpd_pkg::TOTAL_BITS'(total);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at result %0d, %s: got %0d, expected %0d (cycle %0d)",
               results_checked, what, got, want, cycle_count);
      error_count++;
   endtask

   // Compare one accepted result beat with the oldest expectation.
   task automatic check_result(input wvpd_pkg::rsp_type got);
      wvpd_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         flag_mismatch("result beat with nothing expected", longint'(got), 64'sd0);
         return;
      end
      want = expected_results.pop_front();
      if (got.power_state !== want.power_state)
         flag_mismatch("power_state", longint'(got.power_state),
                       longint'(want.power_state));
      if (got.state_changed !== want.state_changed)
         flag_mismatch("state_changed", longint'(got.state_changed),
                       longint'(want.state_changed));
      if (got.vote_sum !== want.vote_sum)
         flag_mismatch("vote_sum", longint'($signed(got.vote_sum)),
                       longint'($signed(want.vote_sum)));
      if (got.weight_total !== want.weight_total)
         flag_mismatch("weight_total", longint'(got.weight_total),
                       longint'(want.weight_total));
      if (got.state_changed === 1'b1) changes_seen++;
      results_checked++;
   endtask

   // Result side: check accepted beats, then choose the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 9);
         end
      end
   end

   // Offer one reading beat and record its expectation when it is taken.
   task automatic send_reading(input wvpd_pkg::req_type item, input logic typed,
                               input wvpd_pkg::rsp_type typed_rsp);
      wvpd_pkg::rsp_type predicted;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted = tally_reading(item);
      expected_results.insert(expected_results.size(), typed ? typed_rsp : predicted);
      readings_sent++;
   endtask

   // Random idle cycles on the input side between beats.
   task automatic sender_gap();
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop offering readings and wait until every result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // One register write beat; valid stays up when another write follows.
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] data, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
      case (idx)
         wvpd_pkg::CSR_HYSTERESIS: cfg_hysteresis = data[7:0];
         wvpd_pkg::CSR_ENABLE:     cfg_enable     = data[7:0];
         wvpd_pkg::CSR_WEIGHTS:    cfg_weights    = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Pick a fresh register setting, leaning toward short debounce.
   task automatic shuffle_config();
      logic [7:0]  h;
      logic [7:0]  en;
      logic [63:0] w;
      int          pick;
      case ($urandom_range(5))
         0: h = 8'd0;
         1: h = 8'd1;
         2: h = 8'd2;
         3: h = 8'd3;
         4: h = 8'($urandom_range(4, 6));
         default: h = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(1, 4));
      endcase
      pick = $urandom_range(9);
      if (pick < 6) en = 8'hFF;
      else if (pick < 9) en = 8'($urandom);
      else en = 8'h00;
      for (int b = 0; b < 8; b++) begin
         pick = $urandom_range(9);
         if (pick == 0) w[8*b +: 8] = 8'h00;
         else if (pick == 1) w[8*b +: 8] = 8'hFF;
         else w[8*b +: 8] = 8'($urandom_range(1, 254));
      end
      wait_idle();
      write_csr(wvpd_pkg::CSR_HYSTERESIS, 64'(h), 1'b1);
      write_csr(wvpd_pkg::CSR_ENABLE, 64'(en), 1'b1);
      write_csr(wvpd_pkg::CSR_WEIGHTS, w, 1'b0);
   endtask

   // Readings that follow a trend, flipped now and then; low stay_pct is noise.
   task automatic drive_readings(input int count, input int stay_pct, input int flip_pct);
      wvpd_pkg::req_type item;
      logic              trend;
      trend = 1'($urandom_range(1));
      repeat (count) begin
         if ($urandom_range(99) < flip_pct) trend = ~trend;
         item.sensor_index = wvpd_pkg::SLOT_BITS'($urandom_range(wvpd_pkg::NUM_SLOTS - 1));
         item.sensor_value = ($urandom_range(99) < stay_pct) ? trend : ~trend;
         sender_gap();
         send_reading(item, 1'b0, '0);
      end
   endtask

   function automatic stim_row_type read_row(input int idx, input bit val);
      stim_row_type row;
      row = '0;
      row.req.sensor_index = wvpd_pkg::SLOT_BITS'(idx);
      row.req.sensor_value = val;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input int idx, input bit val,
                                              input wvpd_pkg::vote_type st,
                                              input bit chg, input int vote, input int total);
      stim_row_type row;
      row = read_row(idx, val);
      row.typed              = 1'b1;
      row.want.power_state   = st;
      row.want.state_changed = chg;
      row.want.vote_sum      = wvpd_pkg::VOTE_BITS'(vote);
      row.want.weight_total  = wvpd_pkg::TOTAL_BITS'(total);
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [63:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr    = 1'b1;
      row.csr_index = idx;
      row.csr_data  = data;
      return row;
   endfunction

   // Append one row to the directed table.
   task automatic add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   initial begin
      reset_tally();

      // Default weights of one: debounce of three before the first change to on.
      add_row(typed_row(0, 1, wvpd_pkg::VOTE_UNKNOWN, 0, 1, 1));
      add_row(typed_row(7, 0, wvpd_pkg::VOTE_UNKNOWN, 0, 0, 2));
      add_row(typed_row(7, 1, wvpd_pkg::VOTE_UNKNOWN, 0, 2, 2));
      add_row(typed_row(0, 1, wvpd_pkg::VOTE_UNKNOWN, 0, 2, 2));
      add_row(typed_row(7, 1, wvpd_pkg::VOTE_ON, 1, 2, 2));
      add_row(typed_row(3, 1, wvpd_pkg::VOTE_ON, 0, 3, 3));
      // Full weights, hysteresis of zero, and a write to the unused index.
      add_row(csr_row(wvpd_pkg::CSR_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(csr_row(wvpd_pkg::CSR_HYSTERESIS, 64'd0));
      add_row(csr_row(CSR_NONE, 64'hA5A5_5A5A_F00F_0FF0));
      for (int i = 0; i < wvpd_pkg::NUM_SENSORS - 1; i++) add_row(read_row(i, 0));
      add_row(typed_row(7, 0, wvpd_pkg::VOTE_OFF, 0, -2040, 2040));
      // Longest debounce: the state holds while the vote swings to full on.
      add_row(csr_row(wvpd_pkg::CSR_HYSTERESIS, 64'd255));
      for (int i = 0; i < wvpd_pkg::NUM_SENSORS - 1; i++) add_row(read_row(i, 1));
      add_row(typed_row(7, 1, wvpd_pkg::VOTE_OFF, 0, 2040, 2040));
      // Zero weights and an empty enable mask both leave no weight at all.
      add_row(csr_row(wvpd_pkg::CSR_WEIGHTS, 64'd0));
      add_row(typed_row(5, 1, wvpd_pkg::VOTE_OFF, 0, 0, 0));
      add_row(csr_row(wvpd_pkg::CSR_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(csr_row(wvpd_pkg::CSR_ENABLE, 64'd0));
      add_row(typed_row(2, 0, wvpd_pkg::VOTE_OFF, 0, 0, 0));
      // Back to the reset values.
      add_row(csr_row(wvpd_pkg::CSR_ENABLE, 64'(wvpd_pkg::ENABLE_RESET)));
      add_row(csr_row(wvpd_pkg::CSR_HYSTERESIS, 64'(wvpd_pkg::HYSTERESIS_RESET)));
      add_row(csr_row(wvpd_pkg::CSR_WEIGHTS, wvpd_pkg::WEIGHTS_RESET));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; writes go in only once the block is drained.
      for (int i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_csr) begin
            if (i == 0 || !directed_rows[i-1].is_csr) wait_idle();
            write_csr(directed_rows[i].csr_index, directed_rows[i].csr_data,
                      i + 1 < directed_rows.size() && directed_rows[i+1].is_csr);
         end else begin
            sender_gap();
            send_reading(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // A stretch with no idling on either side.
      calm = 1'b1;
      drive_readings(100, 85, 4);
      calm = 1'b0;

      // Result side held off while readings keep coming, so the input stalls.
      shuffle_config();
      hold_request = HOLD_CYCLES;
      drive_readings(60, 85, 4);

      // Random settings: trends, frequent flips, then plain noise.
      for (int p = 0; p < 4; p++) begin
         shuffle_config();
         drive_readings(60, (p == 3) ? 50 : 85, (p == 2) ? 20 : 4);
      end

      // A long steady run drives the repeat counter into saturation.
      wait_idle();
      write_csr(wvpd_pkg::CSR_HYSTERESIS, 64'd255, 1'b1);
      write_csr(wvpd_pkg::CSR_ENABLE, 64'hFF, 1'b1);
      write_csr(wvpd_pkg::CSR_WEIGHTS, {$urandom, $urandom} | 64'h0101_0101_0101_0101, 1'b0);
      drive_readings(280, 100, 0);

      // Drain, then leave room for any stray result beat.
      wait_idle();
      repeat (4 * LATENCY) @(posedge clock);

      $display("covered %0d readings and %0d register writes: directed, steady, held-off,",
               readings_sent, csr_writes);
      $display("random and saturating phases; %0d results checked, %0d state changes",
               results_checked, changes_seen);
      if (error_count == 0) begin
         $display("weighted_vote_power_detector_top regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("weighted_vote_power_detector_top regression: fail");
      end
      $finish;
   end

endmodule
